// File: hdl/bssg_pkg.sv
package bssg_pkg;

  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_PHASE_STEP = 3'd0;
  localparam logic [2:0] REG_BURST_SPAN = 3'd1;
  localparam logic [2:0] REG_MOMENT_X   = 3'd2;
  localparam logic [2:0] REG_MOMENT_Y   = 3'd3;
  localparam logic [2:0] REG_MOMENT_Z   = 3'd4;

  localparam logic [14:0]        RST_PHASE_STEP = 15'd3277;
  localparam logic [15:0]        RST_BURST_SPAN = 16'd100;
  localparam logic signed [15:0] RST_MOMENT_X   = 16'sd32767;
  localparam logic signed [15:0] RST_MOMENT_Y   = 16'sd0;
  localparam logic signed [15:0] RST_MOMENT_Z   = 16'sd0;

  localparam logic signed [15:0] SAT_POS  = 16'sh7FFF;
  localparam logic signed [15:0] SAT_NEG  = 16'sh8000;
  localparam logic [14:0]        SINE_MAX = 15'd32767;
  localparam logic [1:0]         LAST_COMP = 2'd2;

  typedef struct packed {
    logic [14:0]        phase_step;
    logic [15:0]        burst_span;
    logic signed [15:0] moment_x;
    logic signed [15:0] moment_y;
    logic signed [15:0] moment_z;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_GAP,
    OP_START,
    OP_SINE,
    OP_MUL1,
    OP_MUL2,
    OP_DIV,
    OP_SF,
    OP_PROD,
    OP_ACC,
    OP_ADV
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_SF,
    S_PROD,
    S_ACC,
    S_ADV,
    S_OUT
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] comp;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic gap_pos;
    logic env_neg;
  } stat_t;

  // quarter-wave table, round(32767*sin(k*pi/64))
  function automatic logic [14:0] sine_q(input logic [5:0] k);
    logic [14:0] v;
    case (k)
      6'd0:  v = 15'd0;
      6'd1:  v = 15'd1608;
      6'd2:  v = 15'd3212;
      6'd3:  v = 15'd4808;
      6'd4:  v = 15'd6393;
      6'd5:  v = 15'd7962;
      6'd6:  v = 15'd9512;
      6'd7:  v = 15'd11039;
      6'd8:  v = 15'd12539;
      6'd9:  v = 15'd14010;
      6'd10: v = 15'd15446;
      6'd11: v = 15'd16846;
      6'd12: v = 15'd18204;
      6'd13: v = 15'd19519;
      6'd14: v = 15'd20787;
      6'd15: v = 15'd22005;
      6'd16: v = 15'd23170;
      6'd17: v = 15'd24279;
      6'd18: v = 15'd25329;
      6'd19: v = 15'd26319;
      6'd20: v = 15'd27245;
      6'd21: v = 15'd28105;
      6'd22: v = 15'd28898;
      6'd23: v = 15'd29621;
      6'd24: v = 15'd30273;
      6'd25: v = 15'd30852;
      6'd26: v = 15'd31356;
      6'd27: v = 15'd31785;
      6'd28: v = 15'd32137;
      6'd29: v = 15'd32412;
      6'd30: v = 15'd32609;
      6'd31: v = 15'd32728;
      default: v = SINE_MAX;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/bssg_regs.sv
module bssg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bssg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output bssg_pkg::cfg_t             cfg
);

  bssg_pkg::cfg_t cfg_r;
  bssg_pkg::cfg_t cfg_nxt;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[4:2])
        bssg_pkg::REG_PHASE_STEP: cfg_nxt.phase_step = pwdata[14:0];
        bssg_pkg::REG_BURST_SPAN: cfg_nxt.burst_span = pwdata[15:0];
        bssg_pkg::REG_MOMENT_X:   cfg_nxt.moment_x   = pwdata[15:0];
        bssg_pkg::REG_MOMENT_Y:   cfg_nxt.moment_y   = pwdata[15:0];
        bssg_pkg::REG_MOMENT_Z:   cfg_nxt.moment_z   = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      bssg_pkg::REG_PHASE_STEP: prdata = {17'h0, cfg_r.phase_step};
      bssg_pkg::REG_BURST_SPAN: prdata = {16'h0, cfg_r.burst_span};
      bssg_pkg::REG_MOMENT_X:   prdata = {16'h0, cfg_r.moment_x};
      bssg_pkg::REG_MOMENT_Y:   prdata = {16'h0, cfg_r.moment_y};
      bssg_pkg::REG_MOMENT_Z:   prdata = {16'h0, cfg_r.moment_z};
      default:                  prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step <= bssg_pkg::RST_PHASE_STEP;
      cfg_r.burst_span <= bssg_pkg::RST_BURST_SPAN;
      cfg_r.moment_x   <= bssg_pkg::RST_MOMENT_X;
      cfg_r.moment_y   <= bssg_pkg::RST_MOMENT_Y;
      cfg_r.moment_z   <= bssg_pkg::RST_MOMENT_Z;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hdl/bssg_ctrl.sv
module bssg_ctrl #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  bssg_pkg::stat_t stat,
  output bssg_pkg::cmd_t  cmd
);

  localparam int CW = $clog2(SAMPLE_BITS - 1);
  localparam logic [CW-1:0] DIV_LAST = CW'(SAMPLE_BITS - 2);

  bssg_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]       comp_r, comp_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == bssg_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    comp_nxt     = comp_r;
    cmd.op       = bssg_pkg::OP_NONE;
    cmd.comp     = comp_r;
    cmd.load_out = 1'b0;
    case (state_r)
      bssg_pkg::S_IDLE: begin
        if (in_valid) begin
          if (stat.gap_pos) begin
            cmd.op    = bssg_pkg::OP_GAP;
            state_nxt = bssg_pkg::S_OUT;
          end else if (stat.env_neg) begin
            cmd.op    = bssg_pkg::OP_START;
            state_nxt = bssg_pkg::S_OUT;
          end else begin
            cmd.op    = bssg_pkg::OP_SINE;
            state_nxt = bssg_pkg::S_MUL1;
          end
        end
      end
      bssg_pkg::S_MUL1: begin
        cmd.op    = bssg_pkg::OP_MUL1;
        state_nxt = bssg_pkg::S_MUL2;
      end
      bssg_pkg::S_MUL2: begin
        cmd.op    = bssg_pkg::OP_MUL2;
        cnt_nxt   = '0;
        state_nxt = bssg_pkg::S_DIV;
      end
      bssg_pkg::S_DIV: begin
        cmd.op = bssg_pkg::OP_DIV;
        if (cnt_r == DIV_LAST) begin
          state_nxt = bssg_pkg::S_SF;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      bssg_pkg::S_SF: begin
        cmd.op    = bssg_pkg::OP_SF;
        comp_nxt  = '0;
        state_nxt = bssg_pkg::S_PROD;
      end
      bssg_pkg::S_PROD: begin
        cmd.op    = bssg_pkg::OP_PROD;
        state_nxt = bssg_pkg::S_ACC;
      end
      bssg_pkg::S_ACC: begin
        cmd.op = bssg_pkg::OP_ACC;
        if (comp_r == bssg_pkg::LAST_COMP) begin
          state_nxt = bssg_pkg::S_ADV;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = bssg_pkg::S_PROD;
        end
      end
      bssg_pkg::S_ADV: begin
        cmd.op    = bssg_pkg::OP_ADV;
        state_nxt = bssg_pkg::S_OUT;
      end
      bssg_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = bssg_pkg::S_IDLE;
        end
      end
      default: state_nxt = bssg_pkg::S_IDLE;
    endcase
    out_valid_nxt = cmd.load_out || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bssg_pkg::S_IDLE;
      cnt_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/bssg_dp.sv
module bssg_dp #(
  parameter int PHASE_BITS  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bssg_pkg::cfg_t     cfg,
  input  bssg_pkg::cmd_t     cmd,
  input  logic [15:0]        in_rand_phase,
  input  logic [15:0]        in_rand_gap,
  input  logic [15:0]        in_rand_half,
  output bssg_pkg::stat_t    stat,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic               out_burst_active
);

  localparam int PB    = PHASE_BITS;
  localparam int SB    = SAMPLE_BITS;
  localparam int QB    = PB - 2;
  localparam int FB    = PB - 7;
  localparam int A_UP  = (PB >= 16) ? PB - 16 : 0;
  localparam int A_DN  = (PB >= 16) ? 0 : 16 - PB;
  localparam int S_UP  = (SB >= 16) ? SB - 16 : 0;
  localparam int S_DN  = (SB >= 16) ? 0 : 16 - SB;
  localparam int SW    = SB - 1;
  localparam int IPW   = 11 + FB;
  localparam int SFW   = 2 * SB - 1;
  localparam int PLW   = 16 + SB;
  localparam int PHW   = 16 + SB - 1;
  localparam int SH    = 2 * SB - 2;
  localparam int FULLW = 2 * SB + 16;
  localparam int RW    = FULLW - SH;
  localparam logic [QB:0] QUARTER = (QB + 1)'(1) << QB;

  function automatic logic [PB-1:0] align_turn(input logic [15:0] v);
    return PB'((32'(v) << A_UP) >> A_DN);
  endfunction

  // sample state
  logic [PB-1:0]      phase_r, phase_nxt;
  logic signed [17:0] gap_cnt_r, gap_cnt_nxt;
  logic signed [17:0] env_cnt_r, env_cnt_nxt;
  logic [16:0]        half_r, half_nxt;
  logic signed [15:0] held_r [3];
  logic signed [15:0] held_nxt [3];
  logic               active_r, active_nxt;

  // work registers
  logic [14:0]        base_r, base_nxt;
  logic [10:0]        diff_r, diff_nxt;
  logic [FB-1:0]      fr_r, fr_nxt;
  logic               sneg_r, sneg_nxt;
  logic [16:0]        ad_r, ad_nxt;
  logic [IPW-1:0]     ip_r, ip_nxt;
  logic [33:0]        hh_r, hh_nxt;
  logic [33:0]        dd_r, dd_nxt;
  logic [SW-1:0]      s_r, s_nxt;
  logic [34:0]        rem_r, rem_nxt;
  logic [SB-1:0]      quo_r, quo_nxt;
  logic [SFW-1:0]     sf_r, sf_nxt;
  logic [PLW-1:0]     plo_r, plo_nxt;
  logic [PHW-1:0]     phi_r, phi_nxt;
  logic               neg_r, neg_nxt;
  logic signed [15:0] ox_r, oy_r, oz_r, ox_nxt, oy_nxt, oz_nxt;
  logic               oact_r, oact_nxt;

  // combinational terms
  logic [1:0]         quad;
  logic [QB:0]        pos_raw, pos;
  logic [5:0]         tidx;
  logic [14:0]        t_lo, t_hi;
  logic [31:0]        gap_prod, half_prod;
  logic [16:0]        half_new;
  logic signed [18:0] env_dev;
  logic [IPW:0]       ip_rnd;
  logic [14:0]        mag;
  logic [33:0]        dd_min, env_num;
  logic               q0;
  logic [34:0]        rem2;
  logic               qbit;
  logic signed [15:0] mom;
  logic [15:0]        am;
  logic [FULLW-1:0]   full;
  logic [RW-1:0]      rmag;
  logic signed [15:0] sat;

  assign stat.gap_pos = !gap_cnt_r[17] && (gap_cnt_r != '0);
  assign stat.env_neg = env_cnt_r[17];

  assign quad    = phase_r[PB-1:PB-2];
  assign pos_raw = {1'b0, phase_r[QB-1:0]};
  assign pos     = quad[0] ? (QUARTER - pos_raw) : pos_raw;
  assign tidx    = pos[QB:FB];
  assign t_lo    = bssg_pkg::sine_q(tidx);
  assign t_hi    = bssg_pkg::sine_q(tidx + 6'd1);

  assign gap_prod  = 32'(cfg.burst_span) * 32'(in_rand_gap);
  assign half_prod = 32'(cfg.burst_span) * 32'(in_rand_half);
  assign half_new  = {1'b0, half_prod[31:16]} + 17'd1;

  assign env_dev = 19'(env_cnt_r) - $signed({2'b00, half_r});

  assign ip_rnd = (IPW + 1)'(ip_r) + ((IPW + 1)'(1) << (FB - 1));
  assign mag    = base_r + 15'(ip_rnd >> FB);

  assign dd_min  = (dd_r > hh_r) ? hh_r : dd_r;
  assign env_num = hh_r - dd_min;
  assign q0      = (env_num >= hh_r);

  assign rem2 = rem_r << 1;
  assign qbit = (rem2 >= 35'(hh_r));

  always_comb begin
    case (cmd.comp)
      2'd0:    mom = cfg.moment_x;
      2'd1:    mom = cfg.moment_y;
      default: mom = cfg.moment_z;
    endcase
  end

  assign am = mom[15] ? 16'(-mom) : mom;

  assign full = FULLW'(plo_r) + (FULLW'(phi_r) << SB) + (FULLW'(1) << (SH - 1));
  assign rmag = RW'(full >> SH);

  always_comb begin
    if (neg_r) begin
      sat = (rmag > RW'(32768)) ? bssg_pkg::SAT_NEG : 16'(-rmag);
    end else begin
      sat = (rmag > RW'(32767)) ? bssg_pkg::SAT_POS : 16'(rmag);
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    gap_cnt_nxt = gap_cnt_r;
    env_cnt_nxt = env_cnt_r;
    half_nxt    = half_r;
    held_nxt    = held_r;
    active_nxt  = active_r;
    base_nxt    = base_r;
    diff_nxt    = diff_r;
    fr_nxt      = fr_r;
    sneg_nxt    = sneg_r;
    ad_nxt      = ad_r;
    ip_nxt      = ip_r;
    hh_nxt      = hh_r;
    dd_nxt      = dd_r;
    s_nxt       = s_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    sf_nxt      = sf_r;
    plo_nxt     = plo_r;
    phi_nxt     = phi_r;
    neg_nxt     = neg_r;
    case (cmd.op)
      bssg_pkg::OP_GAP: begin
        gap_cnt_nxt = gap_cnt_r - 18'sd1;
        active_nxt  = 1'b0;
      end
      bssg_pkg::OP_START: begin
        phase_nxt   = align_turn(in_rand_phase);
        gap_cnt_nxt = $signed({2'b00, gap_prod[31:16]});
        half_nxt    = half_new;
        env_cnt_nxt = $signed({half_new, 1'b0});
        held_nxt[0] = '0;
        held_nxt[1] = '0;
        held_nxt[2] = '0;
        active_nxt  = 1'b0;
      end
      bssg_pkg::OP_SINE: begin
        gap_cnt_nxt = -18'sd1;
        fr_nxt      = pos[FB-1:0];
        sneg_nxt    = quad[1];
        ad_nxt      = env_dev[18] ? 17'(-env_dev) : 17'(env_dev);
        if (tidx[5]) begin
          base_nxt = bssg_pkg::SINE_MAX;
          diff_nxt = '0;
        end else begin
          base_nxt = t_lo;
          diff_nxt = 11'(t_hi - t_lo);
        end
      end
      bssg_pkg::OP_MUL1: begin
        ip_nxt = IPW'(diff_r) * IPW'(fr_r);
        hh_nxt = 34'(half_r) * 34'(half_r);
        dd_nxt = 34'(ad_r) * 34'(ad_r);
      end
      bssg_pkg::OP_MUL2: begin
        s_nxt   = SW'((32'(mag) << S_UP) >> S_DN);
        rem_nxt = 35'(q0 ? (env_num - hh_r) : env_num);
        quo_nxt = SB'(q0);
      end
      bssg_pkg::OP_DIV: begin
        rem_nxt = qbit ? (rem2 - 35'(hh_r)) : rem2;
        quo_nxt = {quo_r[SB-2:0], qbit};
      end
      bssg_pkg::OP_SF: begin
        sf_nxt = SFW'(s_r) * SFW'(quo_r);
      end
      bssg_pkg::OP_PROD: begin
        plo_nxt = PLW'(am) * PLW'(sf_r[SB-1:0]);
        phi_nxt = PHW'(am) * PHW'(sf_r[SFW-1:SB]);
        neg_nxt = sneg_r ^ mom[15];
      end
      bssg_pkg::OP_ACC: begin
        case (cmd.comp)
          2'd0:    held_nxt[0] = sat;
          2'd1:    held_nxt[1] = sat;
          default: held_nxt[2] = sat;
        endcase
      end
      bssg_pkg::OP_ADV: begin
        phase_nxt   = phase_r + align_turn({1'b0, cfg.phase_step});
        env_cnt_nxt = env_cnt_r - 18'sd1;
        active_nxt  = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    oz_nxt   = oz_r;
    oact_nxt = oact_r;
    if (cmd.load_out) begin
      ox_nxt   = held_r[0];
      oy_nxt   = held_r[1];
      oz_nxt   = held_r[2];
      oact_nxt = active_r;
    end
  end

  assign out_x            = ox_r;
  assign out_y            = oy_r;
  assign out_z            = oz_r;
  assign out_burst_active = oact_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      gap_cnt_r <= -18'sd1;
      env_cnt_r <= -18'sd1;
      half_r    <= '0;
      held_r[0] <= bssg_pkg::RST_MOMENT_X;
      held_r[1] <= bssg_pkg::RST_MOMENT_Y;
      held_r[2] <= bssg_pkg::RST_MOMENT_Z;
      active_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      gap_cnt_r <= gap_cnt_nxt;
      env_cnt_r <= env_cnt_nxt;
      half_r    <= half_nxt;
      held_r    <= held_nxt;
      active_r  <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    diff_r <= diff_nxt;
    fr_r   <= fr_nxt;
    sneg_r <= sneg_nxt;
    ad_r   <= ad_nxt;
    ip_r   <= ip_nxt;
    hh_r   <= hh_nxt;
    dd_r   <= dd_nxt;
    s_r    <= s_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    sf_r   <= sf_nxt;
    plo_r  <= plo_nxt;
    phi_r  <= phi_nxt;
    neg_r  <= neg_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    oz_r   <= oz_nxt;
    oact_r <= oact_nxt;
  end

endmodule

// File: hdl/burst_sine_source_generator.sv
// Channel  Handshake           Payload
// in       in_valid/in_ready   in_rand_phase, in_rand_gap, in_rand_half
// out      out_valid/out_ready out_x, out_y, out_z, out_burst_active
// cfg      psel/penable/pready paddr, pwrite, pwdata, prdata
//
// Gap and burst-start beats go straight from idle to the output state; burst beats
// take longer, set by the restoring envelope divider (SAMPLE_BITS-1 steps)
// and the three-component multiply loop.
// One beat is worked on at a time; in_ready is high only when idle.
// A stalled result waits in the output register while the next beat is
// taken and worked on; it then waits in the final state.
// rst_n is synchronous: registers with reset values take them at the next rising edge.
module burst_sine_source_generator #(
  parameter int PHASE_BITS  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [15:0]                 in_rand_phase,
  input  logic [15:0]                 in_rand_gap,
  input  logic [15:0]                 in_rand_half,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          out_x,
  output logic signed [15:0]          out_y,
  output logic signed [15:0]          out_z,
  output logic                        out_burst_active,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bssg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  bssg_pkg::cfg_t  cfg;
  bssg_pkg::cmd_t  cmd;
  bssg_pkg::stat_t stat;

  bssg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bssg_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bssg_dp #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .in_rand_phase    (in_rand_phase),
    .in_rand_gap      (in_rand_gap),
    .in_rand_half     (in_rand_half),
    .stat             (stat),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_z            (out_z),
    .out_burst_active (out_burst_active)
  );

endmodule

// File: hdl/bssg_checker.sv
module bssg_props (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic signed [15:0] out_z,
  input logic               out_burst_active
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(out_burst_active))
    else $error("stalled result beat changed");

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a beat is in work");

  a_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_burst_active |-> out_x == 16'sd0 && out_y == 16'sd0
      && out_z == 16'sd0)
    else $error("non-burst beat carries a non-zero vector");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("handshake not idle after reset");

endmodule

bind burst_sine_source_generator bssg_props u_bssg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_x            (out_x),
  .out_y            (out_y),
  .out_z            (out_z),
  .out_burst_active (out_burst_active)
);

// File: tb/bssg_checker.sv
module bssg_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [15:0]                 in_rand_phase,
  input  logic [15:0]                 in_rand_gap,
  input  logic [15:0]                 in_rand_half,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [15:0]          out_x,
  input  logic signed [15:0]          out_y,
  input  logic signed [15:0]          out_z,
  input  logic                        out_burst_active,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bssg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          mismatches,
  output int                          outstanding
);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               active;
  } sample_t;

  // quarter wave, entry k at bits [16k +: 16]
  localparam logic [33*16-1:0] QWAVE = {
    16'd32767, 16'd32728, 16'd32609, 16'd32412, 16'd32137, 16'd31785, 16'd31356,
    16'd30852, 16'd30273, 16'd29621, 16'd28898, 16'd28105, 16'd27245, 16'd26319,
    16'd25329, 16'd24279, 16'd23170, 16'd22005, 16'd20787, 16'd19519, 16'd18204,
    16'd16846, 16'd15446, 16'd14010, 16'd12539, 16'd11039, 16'd9512,  16'd7962,
    16'd6393,  16'd4808,  16'd3212,  16'd1608,  16'd0
  };

  logic [14:0]        step_reg;
  logic [15:0]        span_reg;
  logic signed [15:0] mom [3];

  logic [15:0]        acc_phase;
  int                 gap_left;
  int                 env_left;
  logic [16:0]        half_ticks;
  logic signed [15:0] held [3];

  sample_t            samples_due [$];
  int                 fail_tally;

  task automatic flag(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    fail_tally++;
  endtask

  function automatic logic [15:0] sine_abs(input logic [15:0] p);
    int unsigned pos, idx, fr, lo, hi;
    pos = p[13:0];
    if (p[14]) pos = 16384 - pos;
    idx = pos >> 9;
    fr  = pos & 511;
    if (idx >= 32) return 16'd32767;
    lo = QWAVE[idx*16 +: 16];
    hi = QWAVE[(idx+1)*16 +: 16];
    return 16'(lo + (((hi - lo) * fr + 256) >> 9));
  endfunction

  task automatic advance_tick(input logic [15:0] r_ph, input logic [15:0] r_gp,
                              input logic [15:0] r_hf, output sample_t smp);
    logic [15:0]        mag;
    logic               sneg;
    longint unsigned    hh, dd, ad, fac, am, r;
    int                 d, mi;
    logic               act;
    act = 1'b0;
    if (gap_left > 0) begin
      gap_left--;
    end else begin
      gap_left = -1;
      if (env_left < 0) begin
        acc_phase  = r_ph;
        gap_left   = int'((32'(span_reg) * 32'(r_gp)) >> 16);
        half_ticks = 17'(((32'(span_reg) * 32'(r_hf)) >> 16) + 1);
        env_left   = 2 * int'(half_ticks);
        for (int k = 0; k < 3; k++) held[k] = '0;
      end else begin
        mag  = sine_abs(acc_phase);
        sneg = acc_phase[15];
        fac  = 0;
        if (half_ticks != 0) begin
          d   = env_left - int'(half_ticks);
          ad  = longint'(d < 0 ? -d : d);
          hh  = longint'(half_ticks) * longint'(half_ticks);
          dd  = ad * ad;
          if (dd > hh) dd = hh;
          fac = ((hh - dd) << 15) / hh;
        end
        for (int k = 0; k < 3; k++) begin
          mi = int'(mom[k]);
          am = longint'(mi < 0 ? -mi : mi);
          r  = (am * longint'(mag) * fac + (64'd1 << 29)) >> 30;
          if (sneg != (mi < 0))
            held[k] = (r > 32768) ? bssg_pkg::SAT_NEG : 16'(-int'(r));
          else
            held[k] = (r > 32767) ? bssg_pkg::SAT_POS : 16'(r);
        end
        acc_phase = acc_phase + 16'(step_reg);
        env_left--;
        act = 1'b1;
      end
    end
    smp = '{held[0], held[1], held[2], act};
  endtask

  task automatic check_beat;
    sample_t want;
    if (samples_due.size() == 0) begin
      flag("result beat with nothing outstanding", int'(out_x), 0);
      return;
    end
    want = samples_due.pop_front();
    if (out_x !== want.x) flag("out_x", int'(out_x), int'(want.x));
    if (out_y !== want.y) flag("out_y", int'(out_y), int'(want.y));
    if (out_z !== want.z) flag("out_z", int'(out_z), int'(want.z));
    if (out_burst_active !== want.active)
      flag("out_burst_active", int'(out_burst_active), int'(want.active));
  endtask

  always @(posedge clk) begin
    sample_t smp;
    if (!rst_n) begin
      step_reg   = bssg_pkg::RST_PHASE_STEP;
      span_reg   = bssg_pkg::RST_BURST_SPAN;
      mom[0]     = bssg_pkg::RST_MOMENT_X;
      mom[1]     = bssg_pkg::RST_MOMENT_Y;
      mom[2]     = bssg_pkg::RST_MOMENT_Z;
      acc_phase  = '0;
      gap_left   = -1;
      env_left   = -1;
      half_ticks = '0;
      for (int k = 0; k < 3; k++) held[k] = mom[k];
      samples_due.delete();
    end else begin
      if (out_valid && out_ready) check_beat();
      if (in_valid && in_ready) begin
        advance_tick(in_rand_phase, in_rand_gap, in_rand_half, smp);
        samples_due.push_back(smp);
      end
      if (psel && penable && pwrite && pready) begin
        case (3'(paddr >> 2))
          bssg_pkg::REG_PHASE_STEP: step_reg = pwdata[14:0];
          bssg_pkg::REG_BURST_SPAN: span_reg = pwdata[15:0];
          bssg_pkg::REG_MOMENT_X:   mom[0]   = pwdata[15:0];
          bssg_pkg::REG_MOMENT_Y:   mom[1]   = pwdata[15:0];
          bssg_pkg::REG_MOMENT_Z:   mom[2]   = pwdata[15:0];
          default: ;
        endcase
      end
    end
    outstanding <= samples_due.size();
    mismatches  <= fail_tally;
  end

  initial fail_tally = 0;

endmodule

// File: tb/tb.sv
module tb;

  localparam int QUIET_LIMIT = 2000;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [15:0]                 in_rand_phase = '0;
  logic [15:0]                 in_rand_gap = '0;
  logic [15:0]                 in_rand_half = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b1;
  logic signed [15:0]          out_x, out_y, out_z;
  logic                        out_burst_active;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [bssg_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  int mismatches;
  int outstanding;
  int quiet;

  always #4 clk = ~clk;

  burst_sine_source_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_rand_phase(in_rand_phase), .in_rand_gap(in_rand_gap), .in_rand_half(in_rand_half),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_burst_active(out_burst_active),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bssg_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_rand_phase(in_rand_phase), .in_rand_gap(in_rand_gap), .in_rand_half(in_rand_half),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_burst_active(out_burst_active),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 4);
    if (r < 90) return $urandom_range(5, 35);
    return $urandom_range(40, 80);
  endfunction

  task automatic send_tick(input logic [15:0] ph, input logic [15:0] gp,
                           input logic [15:0] hf, input bit steady);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_rand_phase <= ph;
    in_rand_gap   <= gp;
    in_rand_half  <= hf;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [14:0] step, input logic [15:0] span,
                              input logic [15:0] mx, input logic [15:0] my,
                              input logic [15:0] mz);
    write_reg(bssg_pkg::REG_PHASE_STEP, 32'(step));
    write_reg(bssg_pkg::REG_BURST_SPAN, 32'(span));
    write_reg(bssg_pkg::REG_MOMENT_X, 32'(mx));
    write_reg(bssg_pkg::REG_MOMENT_Y, 32'(my));
    write_reg(bssg_pkg::REG_MOMENT_Z, 32'(mz));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver stalls
  initial begin
    int pick;
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 200)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [15:0] sweep [4];
    logic [14:0] step;
    logic [15:0] span, mx, my, mz;
    bit          narrow, steady;
    sweep = '{16'hFFFF, 16'h4000, 16'h8000, 16'hC000};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings; zero gap words give a four-beat cycle, so each phase lands on a start
    for (int i = 0; i < 4; i++)
      repeat (4) send_tick(sweep[i], 16'h0000, 16'h0000, 1'b0);
    drain();

    // frozen phase, zero span, extreme moments
    program_regs(15'd0, 16'd0, 16'h8000, 16'h7FFF, 16'hFFFF);
    repeat (4) send_tick(16'h3FFF, 16'hFFFF, 16'hFFFF, 1'b0);
    repeat (4) send_tick(16'hBFFF, 16'hFFFF, 16'hFFFF, 1'b0);

    for (int ph = 0; ph < 10; ph++) begin
      narrow = 1'b0;
      mx = 16'($urandom);
      my = 16'($urandom);
      mz = 16'($urandom);
      step = 15'($urandom_range(0, 32767));
      span = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(1, 8))
                                         : 16'($urandom_range(9, 120));
      case (ph)
        0: begin
          step = 15'd32767; span = 16'd1;
          mx = 16'h7FFF; my = 16'h8000; mz = 16'h0000;
        end
        1: begin
          step = 15'd1; span = 16'd65535; narrow = 1'b1;
        end
        2: begin
          step = bssg_pkg::RST_PHASE_STEP; span = bssg_pkg::RST_BURST_SPAN;
        end
        default: ;
      endcase
      steady = (ph == 3) || ($urandom_range(0, 3) == 0);
      drain();
      program_regs(step, span, mx, my, mz);
      repeat (170) begin
        if (narrow)
          send_tick(16'($urandom), 16'($urandom_range(0, 63)),
                    16'($urandom_range(0, 63)), steady);
        else
          send_tick(16'($urandom), 16'($urandom), 16'($urandom), steady);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: burst_sine_source_generator.f
hdl/bssg_pkg.sv
hdl/bssg_regs.sv
hdl/bssg_ctrl.sv
hdl/bssg_dp.sv
hdl/burst_sine_source_generator.sv
hdl/bssg_checker.sv
tb/bssg_checker.sv
tb/tb.sv
